FILE: rtl/xxrf_pkg.sv
// shared types and constants of the xon/xoff receive fifo
`default_nettype none

package xxrf_pkg;

	localparam int DEPTH  = 8;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int LIM_W  = 4;
	localparam int CMP_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam int FILL_W = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [LIM_W-1:0] UPPER_RST = LIM_W'(6);
	localparam logic [LIM_W-1:0] LOWER_RST = LIM_W'(3);
	localparam logic [7:0]       XON_RST   = 8'd17;
	localparam logic [7:0]       XOFF_RST  = 8'd19;
	localparam logic [7:0]       END_RST   = 8'd26;

	localparam logic KIND_RX  = 1'b0;
	localparam logic KIND_POP = 1'b1;

	typedef enum logic [2:0] {
		REG_UPPER = 3'd0,
		REG_LOWER = 3'd1,
		REG_XON   = 3'd2,
		REG_XOFF  = 3'd3,
		REG_END   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LIM_W-1:0] upper_limit;
		logic [LIM_W-1:0] lower_limit;
		logic [7:0]       xon_code;
		logic [7:0]       xoff_code;
		logic [7:0]       end_code;
	} cfg_t;

	typedef struct packed {
		logic              out_valid;
		logic              send_ctrl;
		logic [7:0]        ctrl_byte;
		logic              end_seen;
		logic              drained;
		logic              overflow;
		logic [FILL_W-1:0] fill_level;
	} res_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

FILE: rtl/xon_xoff_receive_fifo_top.sv
// top level of the xon/xoff flow controlled receive fifo
// latency: a word accepted at one edge has its result on the result ports in the next cycle
// throughput: one word per cycle; busy is always low, the ring ram takes one write and one read a cycle
// done marks each result for exactly one cycle; out_byte comes from the ram's registered read port
// reset clears pointers, fill count, xoff and end flags and restores register defaults
// ring contents are not cleared by reset
`default_nettype none

module xon_xoff_receive_fifo_top import xxrf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [7:0]        rx_byte,
	output logic                   done,
	output logic                   out_valid,
	output logic      [7:0]        out_byte,
	output logic                   send_ctrl,
	output logic      [7:0]        ctrl_byte,
	output logic                   end_seen,
	output logic                   drained,
	output logic                   overflow,
	output logic      [FILL_W-1:0] fill_level,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t       cfg;
	ram_req_t   ram_req;
	res_t       res_s1;
	logic       accept;
	logic [7:0] rdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	xxrf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	xxrf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (kind),
		.rx_byte (rx_byte),
		.cfg     (cfg),
		.ram_req (ram_req),
		.done_s1 (done),
		.res_s1  (res_s1)
	);

	xxrf_ram #(
		.DEPTH (DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	assign out_valid  = res_s1.out_valid;
	assign out_byte   = res_s1.out_valid ? rdata : 8'd0;
	assign send_ctrl  = res_s1.send_ctrl;
	assign ctrl_byte  = res_s1.ctrl_byte;
	assign end_seen   = res_s1.end_seen;
	assign drained    = res_s1.drained;
	assign overflow   = res_s1.overflow;
	assign fill_level = res_s1.fill_level;

endmodule

`default_nettype wire

FILE: rtl/xxrf_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module xxrf_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/xxrf_cfg.sv
// apb configuration registers
`default_nettype none

module xxrf_cfg import xxrf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_limit <= UPPER_RST;
			cfg_q.lower_limit <= LOWER_RST;
			cfg_q.xon_code    <= XON_RST;
			cfg_q.xoff_code   <= XOFF_RST;
			cfg_q.end_code    <= END_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_UPPER: cfg_q.upper_limit <= pwdata[LIM_W-1:0];
				REG_LOWER: cfg_q.lower_limit <= pwdata[LIM_W-1:0];
				REG_XON:   cfg_q.xon_code    <= pwdata[7:0];
				REG_XOFF:  cfg_q.xoff_code   <= pwdata[7:0];
				REG_END:   cfg_q.end_code    <= pwdata[7:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_UPPER: prdata = DATA_W'(cfg_q.upper_limit);
			REG_LOWER: prdata = DATA_W'(cfg_q.lower_limit);
			REG_XON:   prdata = DATA_W'(cfg_q.xon_code);
			REG_XOFF:  prdata = DATA_W'(cfg_q.xoff_code);
			REG_END:   prdata = DATA_W'(cfg_q.end_code);
			default:   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/xxrf_ctrl.sv
// pointers, fill count, flow control decisions and result register
`default_nettype none

module xxrf_ctrl import xxrf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       kind,
	input  wire logic [7:0] rx_byte,
	input  cfg_t            cfg,
	output ram_req_t        ram_req,
	output logic            done_s1,
	output res_t            res_s1
);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             xoff_q, xoff_d;
	logic             end_q, end_d;
	logic [CMP_W-1:0] cnt_x, upper_x, lower_x;
	logic             is_end, full, empty;
	res_t             res_d;

	assign cnt_x   = CMP_W'(cnt_q);
	assign upper_x = CMP_W'(cfg.upper_limit);
	assign lower_x = CMP_W'(cfg.lower_limit);
	assign is_end  = (rx_byte == cfg.end_code);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);

	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		cnt_d    = cnt_q;
		xoff_d   = xoff_q;
		end_d    = end_q;
		res_d    = '0;
		ram_req  = '0;
		ram_req.waddr = wr_ptr_q;
		ram_req.wdata = rx_byte;
		ram_req.raddr = rd_ptr_q;
		if (kind == KIND_RX) begin
			if (cnt_x >= upper_x && !xoff_q) begin
				xoff_d          = 1'b1;
				res_d.send_ctrl = 1'b1;
				res_d.ctrl_byte = cfg.xoff_code;
			end
			priority if (is_end) begin
				end_d = 1'b1;
			end else if (full) begin
				res_d.overflow = 1'b1;
			end else begin
				ram_req.we = accept;
				wr_ptr_d   = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				cnt_d      = cnt_q + 1'b1;
			end
		end else if (!empty) begin
			if (cnt_x <= lower_x && xoff_q) begin
				xoff_d          = 1'b0;
				res_d.send_ctrl = 1'b1;
				res_d.ctrl_byte = cfg.xon_code;
			end
			res_d.out_valid = 1'b1;
			ram_req.re      = accept;
			rd_ptr_d        = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			cnt_d           = cnt_q - 1'b1;
		end
		res_d.end_seen   = end_d;
		res_d.drained    = end_d && (cnt_d == '0);
		res_d.fill_level = FILL_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			xoff_q   <= 1'b0;
			end_q    <= 1'b0;
			done_s1  <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				rd_ptr_q <= rd_ptr_d;
				wr_ptr_q <= wr_ptr_d;
				cnt_q    <= cnt_d;
				xoff_q   <= xoff_d;
				end_q    <= end_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_POP && empty |=> !res_s1.out_valid)
		else $error("pop from empty buffer");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && res_s1.overflow |-> full)
		else $error("overflow without full buffer");

	a_xoff_state: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && res_s1.send_ctrl && !res_s1.out_valid |-> xoff_q)
		else $error("xoff sent but not in force");

	a_xon_state: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && res_s1.send_ctrl && res_s1.out_valid |-> !xoff_q)
		else $error("xon sent but xoff still in force");

endmodule

`default_nettype wire

FILE: tb/xon_xoff_receive_fifo_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the xon/xoff receive fifo: random and directed words, apb register setup
module xon_xoff_receive_fifo_top_test;
	import xxrf_pkg::*;

	typedef struct {
		logic       kind;
		logic [7:0] rx_byte;
	} link_word_t;

	typedef struct {
		logic              out_valid;
		logic [7:0]        out_byte;
		logic              send_ctrl;
		logic [7:0]        ctrl_byte;
		logic              end_seen;
		logic              drained;
		logic              overflow;
		logic [FILL_W-1:0] fill_level;
	} fifo_result_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PER_SETTING = 205;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              kind;
	logic [7:0]        rx_byte;
	logic              done;
	logic              out_valid;
	logic [7:0]        out_byte;
	logic              send_ctrl;
	logic [7:0]        ctrl_byte;
	logic              end_seen;
	logic              drained;
	logic              overflow;
	logic [FILL_W-1:0] fill_level;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	xon_xoff_receive_fifo_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.rx_byte    (rx_byte),
		.done       (done),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.send_ctrl  (send_ctrl),
		.ctrl_byte  (ctrl_byte),
		.end_seen   (end_seen),
		.drained    (drained),
		.overflow   (overflow),
		.fill_level (fill_level),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// shadow of the block
	cfg_t       cfg_shadow;
	logic [7:0] ring_copy [DEPTH];
	int         rd_idx;
	int         wr_idx;
	int         held;
	bit         xoff_sent;
	bit         end_latched;

	link_word_t   queued_words [$];
	fifo_result_t pending_results [$];
	link_word_t   next_word;
	link_word_t   taken_word;
	fifo_result_t got;
	fifo_result_t want;

	int sender_idle_pct;
	bit word_taken;
	int idle_cycles;
	int errors;
	int words_sent;
	int settings_run;
	int pops_seen;
	int xon_seen;
	int xoff_seen;
	int overflow_seen;
	int drained_seen;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic fifo_result_t flow_control_step(link_word_t w);
		fifo_result_t r;
		r = '{default: '0};
		if (w.kind == KIND_RX) begin
			if (held >= int'(cfg_shadow.upper_limit) && !xoff_sent) begin
				xoff_sent = 1'b1;
				r.send_ctrl = 1'b1;
				r.ctrl_byte = cfg_shadow.xoff_code;
			end
			if (w.rx_byte == cfg_shadow.end_code) begin
				end_latched = 1'b1;
			end else if (held >= DEPTH) begin
				r.overflow = 1'b1;
			end else begin
				ring_copy[PTR_W'(wr_idx)] = w.rx_byte;
				wr_idx = (wr_idx + 1) % DEPTH;
				held++;
			end
		end else if (held != 0) begin
			if (held <= int'(cfg_shadow.lower_limit) && xoff_sent) begin
				xoff_sent = 1'b0;
				r.send_ctrl = 1'b1;
				r.ctrl_byte = cfg_shadow.xon_code;
			end
			r.out_valid = 1'b1;
			r.out_byte = ring_copy[PTR_W'(rd_idx)];
			rd_idx = (rd_idx + 1) % DEPTH;
			held--;
		end
		r.end_seen = end_latched;
		r.drained = end_latched && held == 0;
		r.fill_level = FILL_W'(held);
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] expv, logic [7:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			errors++;
		end
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n && (!start || word_taken)) begin
			if (queued_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				next_word = queued_words.pop_front();
				start <= 1'b1;
				kind <= next_word.kind;
				rx_byte <= next_word.rx_byte;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		word_taken = arst_n && start && !busy;
		if (word_taken) begin
			taken_word.kind = kind;
			taken_word.rx_byte = rx_byte;
			pending_results.push_back(flow_control_step(taken_word));
			words_sent++;
		end
		if (arst_n && done) begin
			got.out_valid = out_valid;
			got.out_byte = out_byte;
			got.send_ctrl = send_ctrl;
			got.ctrl_byte = ctrl_byte;
			got.end_seen = end_seen;
			got.drained = drained;
			got.overflow = overflow;
			got.fill_level = fill_level;
			if (pending_results.size() == 0) begin
				$error("result word with no word outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
				check_field("out_byte", want.out_byte, got.out_byte);
				check_field("send_ctrl", 8'(want.send_ctrl), 8'(got.send_ctrl));
				check_field("ctrl_byte", want.ctrl_byte, got.ctrl_byte);
				check_field("end_seen", 8'(want.end_seen), 8'(got.end_seen));
				check_field("drained", 8'(want.drained), 8'(got.drained));
				check_field("overflow", 8'(want.overflow), 8'(got.overflow));
				check_field("fill_level", 8'(want.fill_level), 8'(got.fill_level));
				pops_seen += int'(want.out_valid);
				overflow_seen += int'(want.overflow);
				drained_seen += int'(want.drained);
				if (want.send_ctrl && want.out_valid)
					xon_seen++;
				else if (want.send_ctrl)
					xoff_seen++;
			end
		end
		if (word_taken || (arst_n && done) || (psel && penable && pwrite && pready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL xon_xoff_receive_fifo_top");
			$finish;
		end
	end

	task automatic write_register(reg_idx_t idx, logic [7:0] value);
		logic [DATA_W-1:0] mask;
		mask = (idx == REG_UPPER || idx == REG_LOWER) ? 32'hF : 32'hFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= ($urandom() & ~mask) | (DATA_W'(value) & mask);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_UPPER: cfg_shadow.upper_limit = value[LIM_W-1:0];
			REG_LOWER: cfg_shadow.lower_limit = value[LIM_W-1:0];
			REG_XON:   cfg_shadow.xon_code = value;
			REG_XOFF:  cfg_shadow.xoff_code = value;
			REG_END:   cfg_shadow.end_code = value;
			default: ;
		endcase
	endtask

	task automatic wait_for_drain();
		while (queued_words.size() != 0 || start || pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic queue_word(logic k, logic [7:0] b);
		link_word_t w;
		w.kind = k;
		w.rx_byte = b;
		queued_words.push_back(w);
	endtask

	// fill and drain bursts with random content, some scattered single words
	task automatic queue_random(int count);
		int left;
		int len;
		logic k;
		left = count;
		while (left > 0) begin
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : 1;
			k = 1'($urandom_range(0, 1));
			repeat (len) begin
				if (left > 0) begin
					if (len == 1)
						k = 1'($urandom_range(0, 1));
					queue_word(k, ($urandom_range(0, 9) == 0) ? cfg_shadow.end_code
						: 8'($urandom_range(0, 255)));
					left--;
				end
			end
		end
	endtask

	task automatic run_setting(bit write_regs, int upper, int lower, int xon, int xoff,
			int endc, int idle_pct);
		if (write_regs) begin
			write_register(REG_UPPER, 8'(upper));
			write_register(REG_LOWER, 8'(lower));
			write_register(REG_XON, 8'(xon));
			write_register(REG_XOFF, 8'(xoff));
			write_register(REG_END, 8'(endc));
		end
		sender_idle_pct = idle_pct;
		settings_run++;
		queue_random(RANDOM_PER_SETTING / 2);
		wait_for_drain();
		queue_random(RANDOM_PER_SETTING - RANDOM_PER_SETTING / 2);
		wait_for_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_RX;
		rx_byte = 8'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		word_taken = 1'b0;
		sender_idle_pct = 36;
		cfg_shadow.upper_limit = UPPER_RST;
		cfg_shadow.lower_limit = LOWER_RST;
		cfg_shadow.xon_code = XON_RST;
		cfg_shadow.xoff_code = XOFF_RST;
		cfg_shadow.end_code = END_RST;
		foreach (ring_copy[i])
			ring_copy[i] = 8'd0;
		rd_idx = 0;
		wr_idx = 0;
		held = 0;
		xoff_sent = 1'b0;
		end_latched = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill past the upper limit into overflow, end code while full, drain to empty
		queue_word(KIND_POP, 8'hFF);
		queue_word(KIND_RX, 8'h00);
		queue_word(KIND_RX, 8'hFF);
		queue_word(KIND_RX, 8'h55);
		queue_word(KIND_RX, 8'hAA);
		queue_word(KIND_RX, 8'h0F);
		queue_word(KIND_RX, 8'hF0);
		queue_word(KIND_RX, 8'h81);
		queue_word(KIND_RX, 8'h7E);
		queue_word(KIND_RX, 8'h33);
		queue_word(KIND_RX, END_RST);
		repeat (9)
			queue_word(KIND_POP, 8'($urandom_range(0, 255)));
		queue_word(KIND_RX, 8'hC3);
		queue_word(KIND_POP, 8'h00);
		wait_for_drain();

		run_setting(1'b0, 0, 0, 0, 0, 0, 36);
		run_setting(1'b1, 0, 0, 8'h00, 8'hFF, 8'h00, 36);
		run_setting(1'b1, 15, 15, 8'hFF, 8'h00, 8'hFF, 36);
		run_setting(1'b1, 8, 8, 8'h80, 8'h7F, 8'h01, 81);
		run_setting(1'b1, 1, 7, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), 81);
		run_setting(1'b1, $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 81);
		run_setting(1'b1, $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 0);
		run_setting(1'b1, 4, 2, 8'd17, 8'd19, 8'd26, 0);

		if (pending_results.size() != 0) begin
			$error("%0d result words never arrived", pending_results.size());
			errors++;
		end
		$display("covered %0d words over %0d register settings: %0d bytes popped, %0d overflows",
			words_sent, settings_run, pops_seen, overflow_seen);
		$display("flow control: %0d xoff and %0d xon sent, %0d drained results, %0d mismatches",
			xoff_seen, xon_seen, drained_seen, errors);
		if (errors == 0)
			$display("PASS xon_xoff_receive_fifo_top");
		else
			$display("FAIL xon_xoff_receive_fifo_top");
		$finish;
	end

endmodule
